/* src/esas_pkg.sv */
// ----------------------------------------------------------------------------
// esas_pkg: shared types and constants for the encoder speed and sector block
// Field widths, configuration codes, reset values and the structs that travel
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package esas_pkg;

    localparam int ANGLE_IN_W = 12;
    localparam int TS_W       = 32;
    localparam int SECTOR_W   = 3;
    localparam int SPEED_W    = 30;
    localparam int OFFSET_W   = 12;
    localparam int POLE_W     = 5;
    localparam int WIN_W      = 20;
    localparam int GAIN_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int QUOT_W     = 29;   // raw speed magnitude never exceeds 480000000

    // 60e6 us/min * 16 (1/16 rpm); divided by dt * 2^ANGLE_BITS later
    localparam logic [29:0]       SPEED_NUM = 30'd960000000;
    localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'h10000;

    localparam logic [OFFSET_W-1:0] RST_OFFSET = 12'd1018;
    localparam logic [POLE_W-1:0]   RST_POLES  = 5'd7;
    localparam logic [WIN_W-1:0]    RST_WINDOW = 20'd2000;
    localparam logic [GAIN_W-1:0]   RST_GAIN   = 17'd13107;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLE_CNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_GAIN  = 2'd3;

    typedef enum logic {
        ACT_INIT   = 1'b0,
        ACT_UPDATE = 1'b1
    } t_action;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [POLE_W-1:0]   poles;
    } t_angle_cfg;

    typedef struct packed {
        logic [WIN_W-1:0]  min_window;
        logic [GAIN_W-1:0] gain;
    } t_speed_cfg;

    // one classified beat as held in the queue
    typedef struct packed {
        t_action               action;
        logic [ANGLE_IN_W-1:0] angle;
        logic [TS_W-1:0]       timestamp;
        logic [ANGLE_IN_W-1:0] elec_angle;
        logic [SECTOR_W-1:0]   sector;
    } t_item;

    typedef struct packed {
        logic [ANGLE_IN_W-1:0]     elec_angle;
        logic [SECTOR_W-1:0]       sector;
        logic signed [SPEED_W-1:0] speed;
        logic                      updated;
    } t_result;

endpackage

/* src/esas_front.sv */
// ----------------------------------------------------------------------------
// esas_front: input classifier
// Takes an input beat, masks the angle, computes electrical angle and sector
// and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module esas_front import esas_pkg::*; #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [ANGLE_IN_W-1:0] i_angle,
    input  logic [TS_W-1:0]       i_timestamp,
    input  t_angle_cfg            i_cfg,
    input  logic                  i_full,
    output logic                  o_push,
    output t_item                 o_item
);

    localparam int AW         = ANGLE_BITS;
    localparam int SECTOR_DIV = ((2 ** AW) + 5) / 6;
    localparam logic [AW-1:0] SEC_B1 = AW'(SECTOR_DIV);
    localparam logic [AW-1:0] SEC_B2 = AW'(2 * SECTOR_DIV);
    localparam logic [AW-1:0] SEC_B3 = AW'(3 * SECTOR_DIV);
    localparam logic [AW-1:0] SEC_B4 = AW'(4 * SECTOR_DIV);
    localparam logic [AW-1:0] SEC_B5 = AW'(5 * SECTOR_DIV);

    logic [AW+ANGLE_IN_W-1:0] w_angle_ext;
    logic [AW+OFFSET_W-1:0]   w_offset_ext;
    logic [AW+ANGLE_IN_W-1:0] w_angle_back;
    logic [AW+ANGLE_IN_W-1:0] w_ea_back;
    logic [AW-1:0]            w_angle;
    logic [AW-1:0]            w_offset;
    logic [AW-1:0]            w_mech;
    logic [AW+POLE_W-1:0]     w_prod;
    logic [AW-1:0]            w_ea;
    logic [SECTOR_W-1:0]      w_sector;

    always_comb begin
        w_angle_ext  = {{AW{1'b0}}, i_angle};
        w_offset_ext = {{AW{1'b0}}, i_cfg.offset};
        w_angle      = w_angle_ext[AW-1:0];
        w_offset     = w_offset_ext[AW-1:0];
        w_mech       = w_angle - w_offset;
        w_prod       = w_mech * i_cfg.poles;
        w_ea         = w_prod[AW-1:0];

        // divide by the sector width through threshold compares
        if (w_ea >= SEC_B5) begin
            w_sector = 3'd5;
        end else if (w_ea >= SEC_B4) begin
            w_sector = 3'd4;
        end else if (w_ea >= SEC_B3) begin
            w_sector = 3'd3;
        end else if (w_ea >= SEC_B2) begin
            w_sector = 3'd2;
        end else if (w_ea >= SEC_B1) begin
            w_sector = 3'd1;
        end else begin
            w_sector = 3'd0;
        end

        w_angle_back = {{ANGLE_IN_W{1'b0}}, w_angle};
        w_ea_back    = {{ANGLE_IN_W{1'b0}}, w_ea};
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.action     = t_action'(i_action);
        o_item.angle      = w_angle_back[ANGLE_IN_W-1:0];
        o_item.timestamp  = i_timestamp;
        o_item.elec_angle = w_ea_back[ANGLE_IN_W-1:0];
        o_item.sector     = w_sector;
    end

endmodule

/* src/esas_fifo.sv */
// ----------------------------------------------------------------------------
// esas_fifo: two-entry item queue
// Decouples the classifier from the speed back end.
// ----------------------------------------------------------------------------
module esas_fifo import esas_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_head
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/esas_back.sv */
// ----------------------------------------------------------------------------
// esas_back: speed sequencer
// Holds the reference and filter state, runs the serial speed divide and the
// filter update, and drives the output register.
// ----------------------------------------------------------------------------
module esas_back import esas_pkg::*; #(
    parameter int ANGLE_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_speed_cfg i_cfg,
    input  logic       i_empty,
    input  t_item      i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_result
);

    localparam int AW     = ANGLE_BITS;
    localparam int DW     = AW + 2;
    localparam int HALF_I = 2 ** (AW - 1);
    localparam logic signed [DW-1:0] D_HALF = DW'(HALF_I);
    localparam logic signed [DW-1:0] D_MOD  = DW'(2 * HALF_I);
    localparam int CNT_W  = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(QUOT_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DIFF,
        ST_FMUL,
        ST_FADD
    } t_state;

    t_state                    r_state;
    logic [ANGLE_IN_W-1:0]     r_ref_angle;
    logic [TS_W-1:0]           r_ref_time;
    logic signed [SPEED_W-1:0] r_filt;
    logic [ANGLE_IN_W-1:0]     r_last_ea;
    logic [SECTOR_W-1:0]       r_last_sector;
    logic [ANGLE_IN_W-1:0]     r_new_angle;
    logic [TS_W-1:0]           r_new_time;
    logic [AW-1:0]             r_absd;
    logic                      r_neg;
    logic [TS_W-1:0]           r_dt;
    logic [QUOT_W-1:0]         r_num;
    logic [TS_W-1:0]           r_rem;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [31:0]        r_diff;
    logic signed [49:0]        r_fprod;
    logic                      r_valid;
    t_result                   r_result;

    logic signed [DW-1:0]  w_delta0;
    logic signed [DW-1:0]  w_delta;
    logic signed [DW-1:0]  w_dabs;
    logic [TS_W-1:0]       w_dt;
    logic [WIN_W-1:0]      w_win;
    logic                  w_sample;
    logic                  w_slot;
    logic                  w_load;
    logic [AW+29:0]        w_spd_prod;
    logic [TS_W:0]         w_trial;
    logic                  w_qbit;
    logic signed [31:0]    w_raw;
    logic [GAIN_W-1:0]     w_gain;
    logic signed [31:0]    w_step;
    logic signed [31:0]    w_filt_sum;

    always_comb begin
        w_delta0 = $signed(DW'(i_head.angle)) - $signed(DW'(r_ref_angle));
        if (w_delta0 >= D_HALF) begin
            w_delta = w_delta0 - D_MOD;
        end else if (w_delta0 <= -D_HALF) begin
            w_delta = w_delta0 + D_MOD;
        end else begin
            w_delta = w_delta0;
        end
        w_dabs   = (w_delta < 0) ? -w_delta : w_delta;
        w_dt     = i_head.timestamp - r_ref_time;
        w_win    = (i_cfg.min_window == '0) ? WIN_W'(1) : i_cfg.min_window;
        w_sample = (w_dt >= {{(TS_W-WIN_W){1'b0}}, w_win});

        w_spd_prod = r_absd * SPEED_NUM;

        // one restoring divide step per cycle
        w_trial = {r_rem, r_num[QUOT_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_dt});

        w_raw  = r_neg ? -$signed({3'b000, r_num}) : $signed({3'b000, r_num});
        w_gain = (i_cfg.gain > GAIN_ONE) ? GAIN_ONE : i_cfg.gain;

        // floor shift: drop the low 16 bits of the two's complement product
        w_step     = r_fprod[47:16];
        w_filt_sum = 32'(r_filt) + w_step;
    end

    assign w_slot   = !r_valid || i_ready;
    assign o_pop    = (r_state == ST_IDLE) && !i_empty && w_slot;
    // load the output register: an init or no-sample update, or the filter add
    assign w_load   = (o_pop && ((i_head.action == ACT_INIT) || !w_sample)) ||
                      (r_state == ST_FADD);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_ref_angle   <= '0;
            r_ref_time    <= '0;
            r_filt        <= '0;
            r_last_ea     <= '0;
            r_last_sector <= '0;
            r_valid       <= 1'b0;
            r_result      <= '0;
            r_new_angle   <= '0;
            r_new_time    <= '0;
            r_absd        <= '0;
            r_neg         <= 1'b0;
            r_dt          <= '0;
            r_num         <= '0;
            r_rem         <= '0;
            r_cnt         <= '0;
            r_diff        <= '0;
            r_fprod       <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        if (i_head.action == ACT_INIT) begin
                            r_ref_angle <= i_head.angle;
                            r_ref_time  <= i_head.timestamp;
                            r_result    <= '{r_last_ea, r_last_sector, r_filt, 1'b0};
                        end else begin
                            r_last_ea     <= i_head.elec_angle;
                            r_last_sector <= i_head.sector;
                            if (w_sample) begin
                                r_absd      <= w_dabs[AW-1:0];
                                r_neg       <= (w_delta < 0);
                                r_dt        <= w_dt;
                                r_new_angle <= i_head.angle;
                                r_new_time  <= i_head.timestamp;
                                r_state     <= ST_MUL;
                            end else begin
                                r_result <= '{i_head.elec_angle, i_head.sector,
                                              r_filt, 1'b0};
                            end
                        end
                    end
                end
                ST_MUL: begin
                    r_num   <= w_spd_prod[AW+QUOT_W-1:AW];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= w_qbit ? TS_W'(w_trial - {1'b0, r_dt}) : w_trial[TS_W-1:0];
                    r_num <= {r_num[QUOT_W-2:0], w_qbit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_BIT) begin
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_diff  <= w_raw - 32'(r_filt);
                    r_state <= ST_FMUL;
                end
                ST_FMUL: begin
                    r_fprod <= $signed({1'b0, w_gain}) * r_diff;
                    r_state <= ST_FADD;
                end
                ST_FADD: begin
                    r_filt      <= w_filt_sum[SPEED_W-1:0];
                    r_ref_angle <= r_new_angle;
                    r_ref_time  <= r_new_time;
                    r_result    <= '{r_last_ea, r_last_sector,
                                     w_filt_sum[SPEED_W-1:0], 1'b1};
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/encoder_speed_and_sector_top.sv */
// ----------------------------------------------------------------------------
// encoder_speed_and_sector_top: rotor angle to electrical sector and speed
// Stream-in encoder samples, stream-out electrical angle, sector and a
// low-pass filtered speed in 1/16 rpm.
// ----------------------------------------------------------------------------
// Each input beat carries a 12-bit mechanical angle and a 32-bit microsecond
// timestamp; tuser selects init (0: store angle and time as the reference)
// or update (1). An update gives the electrical angle
// ((angle - angle_offset) * pole-pair count) mod 2^ANGLE_BITS and its sector
// (0..5), and, once min_window_us has elapsed since the reference, takes a
// speed sample delta*960000000/(dt*2^ANGLE_BITS), folds it into the filter
// with weight filter_gain_q16 and moves the reference. Every input beat gives
// exactly one output beat. An accepted beat is written to the queue; the back
// end then pops an init beat or an update inside the window and loads the
// output register as it pops. A speed sample holds the back end through the
// pop, the speed multiply, 29 serial divide steps, the difference, the filter
// multiply and the filter add, and the back end pops no new beat until the
// filter add has loaded the output register. A full output register holds the
// back end until the beat is taken. A two-entry queue lets the input keep
// flowing while the back end works or the output waits. Write configuration
// only while the block is idle.
// ----------------------------------------------------------------------------
module encoder_speed_and_sector_top import esas_pkg::*; #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // angle[11:0], timestamp_us[43:12], zero pad
    input  logic                  s_axis_tuser,  // action
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,  // electrical_angle[11:0], sector[14:12],
                                                 // speed[44:15], zero pad
    output logic                  m_axis_tuser   // speed_updated
);

    logic [OFFSET_W-1:0] r_offset;
    logic [POLE_W-1:0]   r_poles;
    logic [WIN_W-1:0]    r_window;
    logic [GAIN_W-1:0]   r_gain;

    t_angle_cfg w_angle_cfg;
    t_speed_cfg w_speed_cfg;
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_empty;
    t_item      w_item;
    t_item      w_head;
    t_result    w_result;

    // configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= RST_OFFSET;
            r_poles  <= RST_POLES;
            r_window <= RST_WINDOW;
            r_gain   <= RST_GAIN;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ANGLE_OFFSET: r_offset <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_POLE_CNT:     r_poles  <= i_cfg_wdata[POLE_W-1:0];
                CFG_MIN_WINDOW:   r_window <= i_cfg_wdata[WIN_W-1:0];
                CFG_FILTER_GAIN:  r_gain   <= i_cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_angle_cfg = '{r_offset, r_poles};
    assign w_speed_cfg = '{r_window, r_gain};

    // front end: classify the beat and compute the commutation angle
    esas_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_angle     (s_axis_tdata[11:0]),
        .i_timestamp (s_axis_tdata[43:12]),
        .i_cfg       (w_angle_cfg),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_item)
    );

    // hold classified beats while the back end is busy
    esas_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // back end: reference tracking, speed divide and filter
    esas_back #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_speed_cfg),
        .i_empty  (w_empty),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {3'b000, w_result.speed, w_result.sector, w_result.elec_angle};
    assign m_axis_tuser = w_result.updated;

endmodule
